// ----- hdl/kaf_pkg.sv -----
// Shared types and constants for the Kalman angle filter.
package kaf_pkg;

    localparam logic [1:0] RegDt   = 2'd0;
    localparam logic [1:0] RegR    = 2'd1;
    localparam logic [1:0] RegQa   = 2'd2;
    localparam logic [1:0] RegQb   = 2'd3;

    localparam logic [31:0] ResetDt = 32'd1610613;
    localparam logic [31:0] ResetR  = 32'd740881859;
    localparam logic [31:0] ResetQa = 32'd107374;
    localparam logic [31:0] ResetQb = 32'd322123;
    localparam logic signed [31:0] CovOne = 32'sd1073741824;

    // Datapath operations issued one at a time by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RATE,
        OP_M_RATE,
        OP_ANGLE,
        OP_D0,
        OP_M_D0,
        OP_P00,
        OP_M_D1,
        OP_P01P10,
        OP_M_D3,
        OP_P11,
        OP_ERR_E,
        OP_DIV0,
        OP_DIV1,
        OP_M_K0Y0,
        OP_U00,
        OP_M_K0Y1,
        OP_U01,
        OP_M_K1Y0,
        OP_U10,
        OP_M_K1Y1,
        OP_U11,
        OP_M_K0E,
        OP_UANG,
        OP_M_K1E,
        OP_UBIAS,
        OP_COMMIT
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MULW,
        ST_DIVW,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic start_div;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic e_pos;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -66'sh80000000) begin
            return -32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- hdl/kaf_divider.sv -----
// Restoring divider for rounded Q2.30 gains, one quotient bit per cycle.
module kaf_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic [32:0]         i_den,
    output logic                o_done,
    output logic signed [31:0]  o_quot
);
    localparam int unsigned CntW = 6;
    localparam int unsigned Steps = 63;

    logic [62:0]     r_dividend;
    logic [63:0]     r_rem;
    logic [62:0]     r_quot;
    logic [32:0]     r_den;
    logic            r_neg;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [63:0]     n_rem_sh;
    logic [31:0]     mag;
    logic signed [65:0] signed_q;

    assign mag = i_num[31] ? 32'(-{i_num[31], i_num}) : i_num;
    assign n_rem_sh = {r_rem[62:0], r_dividend[62]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(Steps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // (|n| << 30) + d/2 fits in 63 bits; quotient bits come out MSB first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= ({31'd0, mag} << 30) + 63'(i_den[32:1]);
            r_rem      <= '0;
            r_quot     <= '0;
            r_den      <= i_den;
            r_neg      <= i_num[31];
        end else if (r_busy) begin
            r_dividend <= {r_dividend[61:0], 1'b0};
            if (n_rem_sh >= {31'd0, r_den}) begin
                r_rem  <= n_rem_sh - {31'd0, r_den};
                r_quot <= {r_quot[61:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh;
                r_quot <= {r_quot[61:0], 1'b0};
            end
        end
    end

    assign signed_q = r_neg ? -$signed({3'd0, r_quot}) : $signed({3'd0, r_quot});
    assign o_quot = kaf_pkg::sat32(signed_q);
    assign o_done = r_done;
endmodule

// ----- hdl/kaf_datapath.sv -----
// Filter state, one shared multiplier with rounding, adders and saturation.
module kaf_datapath (
    input  logic               i_clk,
    input  kaf_pkg::t_cmd      i_cmd,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_gyro,
    input  logic signed [31:0] i_accel,
    output kaf_pkg::t_status   o_status,
    output logic signed [31:0] o_angle
);
    logic [31:0] r_dt, r_r, r_qa, r_qb;
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_gyro, r_accel, r_ta, r_tb, r_tc, r_td, r_tp, r_tq;
    logic signed [31:0] r_k0, r_k1, r_err, r_t;
    // R + P00 spans from -2^31 to about 1.5 * 2^32.
    logic signed [33:0] r_e;
    logic signed [32:0] r_ma, r_mb;
    logic signed [65:0] r_prod;
    logic signed [65:0] rnd;
    logic signed [35:0] m;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= kaf_pkg::ResetDt;
            r_r  <= kaf_pkg::ResetR;
            r_qa <= kaf_pkg::ResetQa;
            r_qb <= kaf_pkg::ResetQb;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kaf_pkg::RegDt: r_dt <= i_cfg_data;
                kaf_pkg::RegR:  r_r  <= i_cfg_data;
                kaf_pkg::RegQa: r_qa <= i_cfg_data;
                kaf_pkg::RegQb: r_qb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Product is registered; the rounded shift happens in the next operation.
    always_ff @(posedge i_clk) r_prod <= 66'(r_ma * r_mb);
    assign rnd = r_prod + 66'sd536870912;
    assign m   = 36'(rnd >>> 30);

    assign div_start = i_cmd.start_div;
    assign div_num   = (i_cmd.op == kaf_pkg::OP_DIV0) ? r_tc : r_tp;

    kaf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_e[32:0]),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_p00  <= kaf_pkg::CovOne;
            r_p01  <= '0;
            r_p10  <= '0;
            r_p11  <= kaf_pkg::CovOne;
        end else begin
            case (i_cmd.op)
                kaf_pkg::OP_LOAD: begin
                    r_gyro  <= i_gyro;
                    r_accel <= i_accel;
                    r_ta <= r_ang;  r_tb <= r_bias;
                    r_tc <= r_p00;  r_td <= r_p01;
                    r_tp <= r_p10;  r_tq <= r_p11;
                end
                kaf_pkg::OP_RATE: begin
                    r_t  <= kaf_pkg::sat32(66'(r_gyro) - 66'(r_tb));
                end
                kaf_pkg::OP_M_RATE: begin
                    r_ma <= 33'(r_t); r_mb <= {1'b0, r_dt};
                end
                kaf_pkg::OP_ANGLE: r_ta <= kaf_pkg::sat32(66'(r_ta) + 66'(m));
                kaf_pkg::OP_D0: begin
                    r_t <= kaf_pkg::sat32(66'({1'b0, r_qa}) - 66'(r_td) - 66'(r_tp));
                end
                kaf_pkg::OP_M_D0: begin
                    r_ma <= 33'(r_t); r_mb <= {1'b0, r_dt};
                end
                kaf_pkg::OP_P00: r_tc <= kaf_pkg::sat32(66'(r_tc) + 66'(m));
                kaf_pkg::OP_M_D1: begin
                    r_ma <= 33'(kaf_pkg::sat32(-66'(r_tq))); r_mb <= {1'b0, r_dt};
                end
                kaf_pkg::OP_P01P10: begin
                    r_td <= kaf_pkg::sat32(66'(r_td) + 66'(m));
                    r_tp <= kaf_pkg::sat32(66'(r_tp) + 66'(m));
                end
                kaf_pkg::OP_M_D3: begin
                    r_ma <= 33'(kaf_pkg::sat32(66'({1'b0, r_qb}))); r_mb <= {1'b0, r_dt};
                end
                kaf_pkg::OP_P11: r_tq <= kaf_pkg::sat32(66'(r_tq) + 66'(m));
                kaf_pkg::OP_ERR_E: begin
                    r_err <= kaf_pkg::sat32(66'(r_accel) - 66'(r_ta));
                    r_e   <= 34'(66'({1'b0, r_r}) + 66'(r_tc));
                end
                kaf_pkg::OP_DIV1: r_k0 <= div_q;
                kaf_pkg::OP_M_K0Y0: begin
                    r_k1 <= div_q;
                    r_ma <= 33'(r_k0); r_mb <= 33'(r_tc);
                end
                kaf_pkg::OP_U00: begin
                    r_tc <= kaf_pkg::sat32(66'(r_tc) - 66'(m));
                    r_t  <= r_tc;
                end
                kaf_pkg::OP_M_K0Y1: begin
                    r_ma <= 33'(r_k0); r_mb <= 33'(r_td);
                end
                kaf_pkg::OP_U01: begin
                    r_td <= kaf_pkg::sat32(66'(r_td) - 66'(m));
                    r_gyro <= r_td;
                end
                kaf_pkg::OP_M_K1Y0: begin
                    r_ma <= 33'(r_k1); r_mb <= 33'(r_t);
                end
                kaf_pkg::OP_U10: r_tp <= kaf_pkg::sat32(66'(r_tp) - 66'(m));
                kaf_pkg::OP_M_K1Y1: begin
                    r_ma <= 33'(r_k1); r_mb <= 33'(r_gyro);
                end
                kaf_pkg::OP_U11: r_tq <= kaf_pkg::sat32(66'(r_tq) - 66'(m));
                kaf_pkg::OP_M_K0E: begin
                    r_ma <= 33'(r_k0); r_mb <= 33'(r_err);
                end
                kaf_pkg::OP_UANG: r_ta <= kaf_pkg::sat32(66'(r_ta) + 66'(m));
                kaf_pkg::OP_M_K1E: begin
                    r_ma <= 33'(r_k1); r_mb <= 33'(r_err);
                end
                kaf_pkg::OP_UBIAS: r_tb <= kaf_pkg::sat32(66'(r_tb) + 66'(m));
                kaf_pkg::OP_COMMIT: begin
                    r_ang <= r_ta;  r_bias <= r_tb;
                    r_p00 <= r_tc;  r_p01 <= r_td;
                    r_p10 <= r_tp;  r_p11 <= r_tq;
                end
                default: ;
            endcase
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.e_pos    = (r_e > 34'sd0);
    assign o_angle           = r_ang;
endmodule

// ----- hdl/kaf_controller.sv -----
// Sequencer that steps the datapath through predict and correct.
module kaf_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  kaf_pkg::t_status i_status,
    output kaf_pkg::t_cmd    o_cmd
);
    kaf_pkg::t_state r_state, n_state;
    kaf_pkg::t_op    r_op, n_op;
    logic            r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kaf_pkg::ST_IDLE;
            r_op     <= kaf_pkg::OP_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
        end
    end

    // Multiplies and OP_ERR_E wait in ST_MULW while their results register.
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_ovalid  = r_ovalid;
        o_cmd.op  = kaf_pkg::OP_NONE;
        o_cmd.start_div = 1'b0;
        o_stall   = 1'b1;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            kaf_pkg::ST_IDLE: begin
                o_stall = r_ovalid;
                if (i_valid && !r_ovalid) begin
                    o_cmd.op = kaf_pkg::OP_LOAD;
                    n_op     = kaf_pkg::OP_RATE;
                    n_state  = kaf_pkg::ST_ISSUE;
                end
            end
            kaf_pkg::ST_ISSUE: begin
                o_cmd.op = r_op;
                n_op     = kaf_pkg::t_op'(r_op + 1'b1);
                case (r_op)
                    kaf_pkg::OP_M_RATE, kaf_pkg::OP_M_D0, kaf_pkg::OP_M_D1,
                    kaf_pkg::OP_M_D3, kaf_pkg::OP_M_K0Y0, kaf_pkg::OP_M_K0Y1,
                    kaf_pkg::OP_M_K1Y0, kaf_pkg::OP_M_K1Y1, kaf_pkg::OP_M_K0E,
                    kaf_pkg::OP_M_K1E: n_state = kaf_pkg::ST_MULW;
                    kaf_pkg::OP_ERR_E: n_state = kaf_pkg::ST_MULW;
                    kaf_pkg::OP_DIV0: begin
                        if (!i_status.e_pos) begin
                            o_cmd.op = kaf_pkg::OP_NONE;
                            n_op     = kaf_pkg::OP_COMMIT;
                        end else begin
                            o_cmd.start_div = 1'b1;
                            n_state = kaf_pkg::ST_DIVW;
                        end
                    end
                    kaf_pkg::OP_DIV1: begin
                        o_cmd.start_div = 1'b1;
                        n_state = kaf_pkg::ST_DIVW;
                    end
                    kaf_pkg::OP_COMMIT: begin
                        n_state = kaf_pkg::ST_OUT;
                    end
                    default: ;
                endcase
            end
            kaf_pkg::ST_MULW: n_state = kaf_pkg::ST_ISSUE;
            kaf_pkg::ST_DIVW: begin
                if (i_status.div_done) begin
                    n_state = kaf_pkg::ST_ISSUE;
                end
            end
            kaf_pkg::ST_OUT: begin
                n_ovalid = 1'b1;
                n_state  = kaf_pkg::ST_IDLE;
            end
            default: n_state = kaf_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
endmodule

// ----- hdl/kalman_angle_filter.sv -----
// Top level of the two-state angle and gyro-bias Kalman filter.
// Input channel: i_valid with i_gyro_rate and i_accel_angle; a transaction
// completes when i_valid is high and o_stall is low. Output channel: o_valid
// with o_angle_estimate; a transaction completes when i_stall is low.
// Each item runs through a sequencer that drives one shared 33x33 multiplier
// and a radix-2 divider; the two gain divisions dominate the run time. When
// the innovation variance is not positive, the correction is skipped. One
// item is in work at a time, and the next is taken once the previous result
// has left the output register.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it; unknown indexes are ignored.
// Synchronous active-low reset restores the register defaults, zero angle
// and bias, and unit diagonal covariance. While the receiver stalls the
// result holds and o_stall stays high on the input.
module kalman_angle_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_gyro_rate,
    input  logic signed [31:0] i_accel_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_angle_estimate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    kaf_pkg::t_cmd    cmd;
    kaf_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    kaf_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    kaf_datapath u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_rst_n    (i_rst_n),
        .i_gyro     (i_gyro_rate),
        .i_accel    (i_accel_angle),
        .o_status   (status),
        .o_angle    (o_angle_estimate)
    );
endmodule

// ----- hdl/kaf_checker.sv -----
// Port-level checks for the Kalman angle filter, bound to the top level.
module kaf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_angle_estimate
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_angle_estimate))
        else $error("result changed while stalled");
    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !o_valid)
        else $error("no work after accept");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind kalman_angle_filter kaf_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_angle_estimate (o_angle_estimate)
);
